// File: hw/rtl/fclru_pkg.sv
`timescale 1ns / 1ps
package fclru_pkg;
  localparam int NUM_SETS_DEF = 256;
  localparam int NUM_WAYS_DEF = 8;
  localparam int KEY_W = 104;
  localparam int RANK_OUT_W = 3;
  localparam int IN_W = 112;
  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_SWAP = 1'b1;
endpackage

// File: hw/rtl/flow_cache_lru_transpose_replacement_core.sv
`timescale 1ns / 1ps
// Row read at accept, then match, reorder and write-back in the next cycle,
// with the result registered.
// A new request is not taken while the set row read-modify-write is busy,
// and a result not yet taken holds off the next request.
// Reset clears control, then a clearing pass writes every set row invalid,
// with s_tready low throughout the pass.
module flow_cache_lru_transpose_replacement_core #(
  parameter int NUM_SETS = fclru_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = fclru_pkg::NUM_WAYS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // set_index, source_address, destination_address, source_port,
  // destination_port, protocol_number
  input  logic [fclru_pkg::IN_W-1:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, hit_rank[2:0]
  output logic [7:0]   m_tdata
);
  localparam int KW = fclru_pkg::KEY_W;
  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RW = NUM_WAYS * KW;
  localparam int DW = RW + NUM_WAYS;

  logic policy_mode;
  logic busy;
  logic phase;
  logic clearing;
  logic [SW-1:0] clr_addr;
  logic [SW-1:0] set_r;
  logic [KW-1:0] key_r;
  logic [RW-1:0] row_keys, new_keys;
  logic [NUM_WAYS-1:0] row_valid, new_valid;
  logic ram_we;
  logic [SW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic hit;
  logic [fclru_pkg::RANK_OUT_W-1:0] hit_rank;
  logic [SW-1:0] in_set;
  logic [KW-1:0] in_key;
  logic [SW-1:0] set_lut [256];

  // set index folded into the cache, one entry per 8-bit index value
  for (genvar g = 0; g < 256; g++) begin : g_set_lut
    assign set_lut[g] = SW'(g % NUM_SETS);
  end

  assign in_set = set_lut[s_tdata[7:0]];
  // key: src addr, dst addr, src port, dst port, proto (high to low)
  assign in_key = {s_tdata[39:8], s_tdata[71:40], s_tdata[87:72],
                   s_tdata[103:88], s_tdata[111:104]};

  assign s_tready = !clearing && !busy && (!m_tvalid || m_tready);

  // row layout: way valid bits above the packed keys
  assign ram_we = clearing || (busy && phase);
  assign ram_waddr = clearing ? clr_addr : set_r;
  assign ram_wdata = clearing ? '0 : {new_valid, new_keys};
  assign row_keys = ram_rdata[RW-1:0];
  assign row_valid = ram_rdata[RW +: NUM_WAYS];

  fclru_ram #(.WIDTH(DW), .DEPTH(NUM_SETS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(in_set), .rdata(ram_rdata)
  );

  fclru_update #(.NUM_WAYS(NUM_WAYS)) u_upd (
    .policy_mode(policy_mode), .key(key_r), .row_keys(row_keys),
    .row_valid(row_valid), .new_keys(new_keys), .new_valid(new_valid),
    .hit(hit), .hit_rank(hit_rank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= fclru_pkg::POLICY_LRU;
      busy <= 1'b0;
      phase <= 1'b0;
      m_tvalid <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (clearing) begin
        if (clr_addr == SW'(NUM_SETS - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        policy_mode <= cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
        phase <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
        phase <= 1'b0;
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      set_r <= in_set;
      key_r <= in_key;
    end
    if (busy) begin
      m_tdata <= {4'd0, hit_rank, hit};
    end
  end
endmodule

// File: hw/rtl/fclru_ram.sv
`timescale 1ns / 1ps
module fclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/fclru_update.sv
`timescale 1ns / 1ps
// Match and reorder of one set row: ways packed rank 0 in the low bits.
module fclru_update #(
  parameter int NUM_WAYS = 8
) (
  input  logic                           policy_mode,
  input  logic [fclru_pkg::KEY_W-1:0]    key,
  input  logic [NUM_WAYS*fclru_pkg::KEY_W-1:0] row_keys,
  input  logic [NUM_WAYS-1:0]            row_valid,
  output logic [NUM_WAYS*fclru_pkg::KEY_W-1:0] new_keys,
  output logic [NUM_WAYS-1:0]            new_valid,
  output logic                           hit,
  output logic [fclru_pkg::RANK_OUT_W-1:0] hit_rank
);
  localparam int KW = fclru_pkg::KEY_W;
  localparam int RW = $clog2(NUM_WAYS);

  logic [NUM_WAYS-1:0] match;
  logic [RW-1:0]       rank;
  logic [RW:0]         rank_ext;

  always_comb begin
    rank = '0;
    for (int r = 0; r < NUM_WAYS; r++) begin
      match[r] = row_valid[r] && (row_keys[r*KW +: KW] == key);
      if (match[r]) begin
        rank = RW'(r);
      end
    end
    hit = |match;
    rank_ext = {1'b0, rank};
    hit_rank = hit ? fclru_pkg::RANK_OUT_W'(rank_ext) : '0;
  end

  always_comb begin
    new_keys = row_keys;
    new_valid = row_valid;
    if (policy_mode == fclru_pkg::POLICY_LRU) begin
      // shift down everything above the hit (all of it on a miss), insert at top
      for (int r = 0; r < NUM_WAYS - 1; r++) begin
        if (!hit || (RW'(r) >= rank)) begin
          new_keys[r*KW +: KW] = row_keys[(r+1)*KW +: KW];
          new_valid[r] = row_valid[r+1];
        end
      end
      new_keys[(NUM_WAYS-1)*KW +: KW] = key;
      new_valid[NUM_WAYS-1] = 1'b1;
    end else if (!hit) begin
      new_keys[KW-1:0] = key;
      new_valid[0] = 1'b1;
    end else begin
      for (int r = 0; r < NUM_WAYS - 1; r++) begin
        if (RW'(r) == rank) begin
          new_keys[r*KW +: KW] = row_keys[(r+1)*KW +: KW];
          new_valid[r] = row_valid[r+1];
          new_keys[(r+1)*KW +: KW] = key;
          new_valid[r+1] = 1'b1;
        end
      end
    end
  end
endmodule
